/* rtl/core/lps_pkg.sv */
package lps_pkg;

    localparam int CFG_BITS    = 13;
    localparam int LAP_BITS    = 19;
    localparam int INDEX_BITS  = 12;
    localparam int OUT_TDATA_W = 48;

    localparam int GRID_MIN   = 8;
    localparam int GRID_RESET = 2048;

    localparam int LAP_MAX = 262143;
    localparam int LAP_MIN = -262144;

    typedef logic signed [LAP_BITS-1:0] lap_t;
    typedef logic [INDEX_BITS-1:0]      index_t;

endpackage

/* rtl/core/laplacian_5point_stencil.sv */
// Five-point Laplacian over a square grid that arrives as a raster stream.
// Input channel s_*: one signed sample per transfer, row by row, column by column.
// Output channel m_*: one transfer per interior point, carrying the Laplacian
// (up + down + left + right - 4 * centre), its row and column, and tlast on the
// last interior point of the grid. Border points give no output transfer.
// The grid size is written through cfg_wr_en/cfg_wr_data; the user must write it
// only while the block is idle; the block does not enforce this. A write restarts
// the frame at row 0, column 0. Values below 8 act as 8, above MAX_GRID as MAX_GRID.
// Throughput is one sample per clock while m_tready stays high. The result of a
// sample reaches m_tvalid through two register stages: operand capture, then the
// adder and saturation. The two previous rows live in one simple dual-port line
// memory that is written at the current column and read two columns ahead, so
// every accepted sample does one write and one read.
// Reset clears the counters and the pipeline and sets the grid size to 2048. The
// line memory is not cleared; the first two rows of each frame refill it.
// When the receiver stalls, the output register and the operand stage fill and
// s_tready drops; nothing is lost and transfers resume where they stopped.
module laplacian_5point_stencil
    import lps_pkg::*;
#(
    parameter int MAX_GRID    = 4096,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_W       = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_BITS-1:0]    cfg_wr_data,   // grid_size
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_W-1:0]        s_tdata,       // sample
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,       // laplacian, row_index, column_index
    output logic                   m_tlast        // frame_last
);

    localparam int CW = $clog2(MAX_GRID);
    localparam int NW = CW + 1;
    localparam int SW = (SAMPLE_BITS + 3 > LAP_BITS + 1) ? SAMPLE_BITS + 3 : LAP_BITS + 1;
    localparam int N_RESET = (GRID_RESET > MAX_GRID) ? MAX_GRID : GRID_RESET;
    localparam logic signed [SW-1:0] SAT_HI = SW'(LAP_MAX);
    localparam logic signed [SW-1:0] SAT_LO = SW'(LAP_MIN);

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    logic [NW-1:0] n_reg;
    logic [CW-1:0] n_m1_reg;
    logic [CW-1:0] n_m2_reg;
    logic [31:0]   cfg_ext;
    logic [31:0]   n_clamped;

    logic [CW-1:0] row_reg;
    logic [CW-1:0] row_next;
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;

    logic [2*SAMPLE_BITS-1:0] line_mem [MAX_GRID];
    logic [2*SAMPLE_BITS-1:0] rd_q_reg;
    logic [2*SAMPLE_BITS-1:0] hold_reg;
    sample_t                  left_reg;
    logic [NW-1:0]            ahead_sum;
    logic [CW-1:0]            rd_addr;

    logic    s_acc;
    logic    out_ready;
    logic    emit;
    sample_t s_sample;
    sample_t centre;
    sample_t top;
    sample_t right;

    logic    a_valid_reg;
    sample_t a_top_reg;
    sample_t a_bot_reg;
    sample_t a_left_reg;
    sample_t a_right_reg;
    sample_t a_centre_reg;
    index_t  a_row_reg;
    index_t  a_col_reg;
    logic    a_last_reg;

    logic signed [SW-1:0] lap_sum;
    lap_t                 lap_sat;

    logic   m_valid_reg;
    lap_t   m_lap_reg;
    index_t m_row_reg;
    index_t m_col_reg;
    logic   m_last_reg;

    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !a_valid_reg || out_ready;
    assign s_acc     = s_tvalid && s_tready;
    assign s_sample  = sample_t'(s_tdata[SAMPLE_BITS-1:0]);

    assign centre = sample_t'(hold_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign top    = sample_t'(hold_reg[SAMPLE_BITS-1:0]);
    assign right  = sample_t'(rd_q_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]);

    assign emit = (row_reg >= CW'(2)) && (col_reg >= CW'(1)) && (col_reg <= n_m2_reg);

    always_comb
    begin
        cfg_ext = 32'(cfg_wr_data);
        if (cfg_ext < 32'(GRID_MIN))
        begin
            n_clamped = 32'(GRID_MIN);
        end
        else if (cfg_ext > 32'(MAX_GRID))
        begin
            n_clamped = 32'(MAX_GRID);
        end
        else
        begin
            n_clamped = cfg_ext;
        end
    end

    always_comb
    begin
        ahead_sum = NW'(col_reg) + NW'(2);
        if (ahead_sum >= n_reg)
        begin
            rd_addr = CW'(ahead_sum - n_reg);
        end
        else
        begin
            rd_addr = CW'(ahead_sum);
        end
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (cfg_wr_en)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (s_acc)
        begin
            if (col_reg == n_m1_reg)
            begin
                col_next = '0;
                row_next = (row_reg == n_m1_reg) ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= NW'(N_RESET);
            n_m1_reg <= CW'(N_RESET - 1);
            n_m2_reg <= CW'(N_RESET - 2);
            row_reg  <= '0;
            col_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                n_reg    <= NW'(n_clamped);
                n_m1_reg <= CW'(n_clamped - 32'd1);
                n_m2_reg <= CW'(n_clamped - 32'd2);
            end
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            line_mem[col_reg] <= {s_sample, centre};
            rd_q_reg          <= line_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            hold_reg <= rd_q_reg;
            left_reg <= centre;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_acc)
        begin
            a_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            a_top_reg    <= top;
            a_bot_reg    <= s_sample;
            a_left_reg   <= left_reg;
            a_right_reg  <= right;
            a_centre_reg <= centre;
            a_row_reg    <= INDEX_BITS'(row_reg - CW'(1));
            a_col_reg    <= INDEX_BITS'(col_reg);
            a_last_reg   <= (row_reg == n_m1_reg) && (col_reg == n_m2_reg);
        end
    end

    always_comb
    begin
        lap_sum = SW'(a_top_reg) + SW'(a_bot_reg) + SW'(a_left_reg) + SW'(a_right_reg)
                - (SW'(a_centre_reg) <<< 2);
        if (lap_sum > SAT_HI)
        begin
            lap_sat = lap_t'(LAP_MAX);
        end
        else if (lap_sum < SAT_LO)
        begin
            lap_sat = lap_t'(LAP_MIN);
        end
        else
        begin
            lap_sat = lap_sum[LAP_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            m_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && a_valid_reg)
        begin
            m_lap_reg  <= lap_sat;
            m_row_reg  <= a_row_reg;
            m_col_reg  <= a_col_reg;
            m_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(OUT_TDATA_W - LAP_BITS - 2 * INDEX_BITS){1'b0}},
                       m_col_reg, m_row_reg, m_lap_reg};

endmodule

/* rtl/core/lps_checker.sv */
module lps_checker
    import lps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // A stalled output transfer keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output payload changed while stalled");

    // An empty output register always leaves room for a new sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
    else $error("input stalled while the output register is empty");

    // A result rising after an idle output comes from a sample held in the operand stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result appeared without a matching input transfer");

endmodule

bind laplacian_5point_stencil lps_checker u_lps_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
